// ===== sv/tma_pkg.sv =====
// Shared package of the triangle mesh area accumulator: fixed field widths,
// derived datapath widths and the input and result transaction structs.
// No dependencies.
`default_nettype none

package tma_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned SUM_BITS   = 44;

  // Edge component magnitude, cross component magnitude, root and radicand.
  localparam int unsigned EDGE_BITS  = COORD_BITS;
  localparam int unsigned CROSS_BITS = 2 * COORD_BITS + 1;
  localparam int unsigned ROOT_BITS  = 2 * COORD_BITS + 2;
  localparam int unsigned RAD_BITS   = 2 * ROOT_BITS;

  // Width of the unsaturated sum of accumulator and root.
  localparam int unsigned ADD_BITS = ((SUM_BITS > ROOT_BITS) ? SUM_BITS : ROOT_BITS) + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] bz;
    logic signed [COORD_BITS-1:0] cx_coord;
    logic signed [COORD_BITS-1:0] cy_coord;
    logic signed [COORD_BITS-1:0] cz_coord;
    logic                         last_triangle;
  } tma_in_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] twice_area_sum;
    logic                mesh_done;
  } tma_out_t;

endpackage

`default_nettype wire

// ===== sv/tma_mul.sv =====
// Serial unsigned multiplier lane: radix-4, one two-bit multiplier digit per cycle.
// Standalone; used by the top level of the triangle mesh area accumulator.
`default_nettype none

module tma_mul #(
  parameter int unsigned A_BITS = 12,
  parameter int unsigned B_BITS = 12
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [A_BITS-1:0]         a_i,
  input  wire logic [B_BITS-1:0]         b_i,
  output logic                           done_o,
  output logic [A_BITS+B_BITS-1:0]       prod_o
);

  localparam int unsigned BP    = B_BITS + (B_BITS % 2);
  localparam int unsigned NSTEP = BP / 2;
  localparam int unsigned CW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int unsigned PW    = A_BITS + BP;

  logic [A_BITS-1:0] mcand_q;
  logic [BP-1:0]     mplier_q;
  logic [PW-1:0]     acc_q;
  logic [A_BITS+1:0] part;
  logic [A_BITS+1:0] hi_sum;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  always_comb begin
    case (mplier_q[1:0])
      2'd0:    part = '0;
      2'd1:    part = {2'b00, mcand_q};
      2'd2:    part = {1'b0, mcand_q, 1'b0};
      default: part = {2'b00, mcand_q} + {1'b0, mcand_q, 1'b0};
    endcase
    hi_sum = {2'b00, acc_q[PW-1:BP]} + part;
  end

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == CW'(NSTEP - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Shift the low product digits out below the running partial sum.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= a_i;
      mplier_q <= BP'(b_i);
      acc_q    <= '0;
    end else if (busy_q) begin
      mplier_q <= mplier_q >> 2;
      acc_q    <= {hi_sum, acc_q[BP-1:2]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q[A_BITS+B_BITS-1:0];

endmodule

`default_nettype wire

// ===== sv/tma_sqrt.sv =====
// Serial floor square root: restoring digit-by-digit, one root bit per cycle.
// Standalone; used by the top level of the triangle mesh area accumulator.
`default_nettype none

module tma_sqrt #(
  parameter int unsigned ROOT_BITS = 26
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [2*ROOT_BITS-1:0] rad_i,
  output logic                        done_o,
  output logic [ROOT_BITS-1:0]        root_o
);

  localparam int unsigned RW = 2 * ROOT_BITS;
  localparam int unsigned CW = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;

  logic [RW-1:0]        rad_q;
  logic [ROOT_BITS+1:0] rem_q;
  logic [ROOT_BITS-1:0] root_q;
  logic [ROOT_BITS+1:0] rem_t;
  logic [ROOT_BITS+1:0] trial;
  logic [ROOT_BITS+1:0] diff;
  logic                 fits;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  // Bring down the next two radicand bits and try root*4+1 against them.
  always_comb begin
    rem_t = {rem_q[ROOT_BITS-1:0], rad_q[RW-1:RW-2]};
    trial = {root_q, 2'b01};
    fits  = (rem_t >= trial);
    diff  = rem_t - trial;
  end

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == CW'(ROOT_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? diff : rem_t;
      root_q <= {root_q[ROOT_BITS-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// ===== sv/triangle_mesh_area_accumulator.sv =====
// Top level of the triangle mesh area accumulator; uses tma_pkg, tma_mul, tma_sqrt.
//
// Usage: one triangle (three vertices, signed fixed-point coordinates) is one
// transaction on the in_* channel (valid/ready). For each triangle the block
// forms the edge cross product, its squared length and the floor square root,
// which is twice the triangle area, and adds it to a saturating running sum.
// One result transaction per triangle leaves on the out_* channel carrying
// the sum (one implied fractional bit) and mesh_done, a copy of the last
// flag. After a last triangle the sum clears for the next mesh.
// One triangle is worked on at a time: the next is taken only once the
// result of the last has been written to the output register. The serial
// square root, one root bit per cycle, does the largest share of the work;
// the cross product and squaring lanes take two multiplier bits per cycle.
// Reset clears the running sum and the control state; no result is pending.
// A stalled receiver holds the result in the output register; the next
// triangle is still accepted and worked on, and waits only to be written out.
`default_nettype none

module triangle_mesh_area_accumulator (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire tma_pkg::tma_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output tma_pkg::tma_out_t     out_data_o
);

  localparam int unsigned CB = tma_pkg::COORD_BITS;
  localparam int unsigned EW = tma_pkg::EDGE_BITS + 1;
  localparam int unsigned PB = 2 * tma_pkg::EDGE_BITS;
  localparam int unsigned XB = tma_pkg::CROSS_BITS;
  localparam int unsigned SB = 2 * tma_pkg::CROSS_BITS;
  localparam int unsigned RB = tma_pkg::ROOT_BITS;
  localparam int unsigned LB = tma_pkg::RAD_BITS;
  localparam int unsigned SUMB = tma_pkg::SUM_BITS;
  localparam int unsigned AB = tma_pkg::ADD_BITS;

  // Edges: 0..2 are B-A, 3..5 are C-A. Lanes 2j and 2j+1 form cross component j.
  localparam int unsigned LANE_A [6] = '{1, 2, 2, 0, 0, 1};
  localparam int unsigned LANE_B [6] = '{5, 4, 3, 5, 4, 3};

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL1  = 8'b0000_0010,
    ST_CROSS = 8'b0000_0100,
    ST_MUL2  = 8'b0000_1000,
    ST_SUM1  = 8'b0001_0000,
    ST_SUM2  = 8'b0010_0000,
    ST_SQRT  = 8'b0100_0000,
    ST_ACC   = 8'b1000_0000
  } tma_state_e;

  tma_state_e state_q, state_d;

  logic [CB-1:0]   vert_a [3];
  logic [CB-1:0]   vert_b [3];
  logic [CB-1:0]   vert_c [3];
  logic [EW-1:0]   ediff  [6];
  logic [EW-1:0]   eneg   [6];
  logic [CB-1:0]   emag   [6];
  logic [5:0]      esgn;
  logic [5:0]      esgn_q;
  logic            last_q;

  logic [PB-1:0]   prod   [6];
  logic [5:0]      prod_done;
  logic [5:0]      psgn;
  logic [XB-1:0]   xmag   [3];
  logic [SB-1:0]   sq     [3];
  logic [2:0]      sq_done;
  logic [LB-1:0]   len_q;
  logic [LB-1:0]   len_full;
  logic [RB-1:0]   root;
  logic            sqrt_done;

  logic            in_acc;
  logic            mul1_done;
  logic            mul2_done;
  logic            sq_start;
  logic            sqrt_start;
  logic            out_wr;

  logic [SUMB-1:0] area_acc_q;
  logic [AB-1:0]   sum_wide;
  logic [SUMB-1:0] sum_new;
  logic            out_valid_q;
  tma_pkg::tma_out_t out_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign mul1_done  = &prod_done;
  assign mul2_done  = &sq_done;
  assign sq_start   = (state_q == ST_CROSS);
  assign sqrt_start = (state_q == ST_SUM2);
  assign out_wr     = (state_q == ST_ACC) && (!out_valid_q || out_ready_i);

  // Edge vectors and their sign/magnitude split, straight from the payload.
  always_comb begin
    vert_a[0] = in_data_i.ax;
    vert_a[1] = in_data_i.ay;
    vert_a[2] = in_data_i.az;
    vert_b[0] = in_data_i.bx;
    vert_b[1] = in_data_i.by_coord;
    vert_b[2] = in_data_i.bz;
    vert_c[0] = in_data_i.cx_coord;
    vert_c[1] = in_data_i.cy_coord;
    vert_c[2] = in_data_i.cz_coord;
  end

  for (genvar k = 0; k < 3; k++) begin : g_edge
    assign ediff[k]   = {vert_b[k][CB-1], vert_b[k]} - {vert_a[k][CB-1], vert_a[k]};
    assign ediff[k+3] = {vert_c[k][CB-1], vert_c[k]} - {vert_a[k][CB-1], vert_a[k]};
  end

  for (genvar k = 0; k < 6; k++) begin : g_emag
    assign eneg[k] = -ediff[k];
    assign esgn[k] = ediff[k][EW-1];
    assign emag[k] = esgn[k] ? eneg[k][CB-1:0] : ediff[k][CB-1:0];
  end

  for (genvar k = 0; k < 6; k++) begin : g_cross_lane
    tma_mul #(
      .A_BITS(CB),
      .B_BITS(CB)
    ) u_mul (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(in_acc),
      .a_i    (emag[LANE_A[k]]),
      .b_i    (emag[LANE_B[k]]),
      .done_o (prod_done[k]),
      .prod_o (prod[k])
    );
    assign psgn[k] = esgn_q[LANE_A[k]] ^ esgn_q[LANE_B[k]];
  end

  // Magnitude of sa*pa - sb*pb: a sum when the signs differ, else |pa - pb|.
  for (genvar j = 0; j < 3; j++) begin : g_cross
    logic [PB:0]   psum;
    logic [PB-1:0] pdiff;
    assign psum  = {1'b0, prod[2*j]} + {1'b0, prod[2*j+1]};
    assign pdiff = (prod[2*j] >= prod[2*j+1]) ? (prod[2*j] - prod[2*j+1])
                                              : (prod[2*j+1] - prod[2*j]);
    assign xmag[j] = (psgn[2*j] ^ psgn[2*j+1]) ? psum : {1'b0, pdiff};
  end

  for (genvar j = 0; j < 3; j++) begin : g_square_lane
    tma_mul #(
      .A_BITS(XB),
      .B_BITS(XB)
    ) u_sq (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(sq_start),
      .a_i    (xmag[j]),
      .b_i    (xmag[j]),
      .done_o (sq_done[j]),
      .prod_o (sq[j])
    );
  end

  assign len_full = len_q + {2'b00, sq[2]};

  tma_sqrt #(
    .ROOT_BITS(RB)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_start),
    .rad_i  (len_full),
    .done_o (sqrt_done),
    .root_o (root)
  );

  // Saturating add of the root to the running sum.
  always_comb begin
    sum_wide = AB'(area_acc_q) + AB'(root);
    sum_new  = (|sum_wide[AB-1:SUMB]) ? '1 : sum_wide[SUMB-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_MUL1;
      ST_MUL1:  if (mul1_done) state_d = ST_CROSS;
      ST_CROSS: state_d = ST_MUL2;
      ST_MUL2:  if (mul2_done) state_d = ST_SUM1;
      ST_SUM1:  state_d = ST_SUM2;
      ST_SUM2:  state_d = ST_SQRT;
      ST_SQRT:  if (sqrt_done) state_d = ST_ACC;
      ST_ACC:   if (out_wr) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      area_acc_q  <= '0;
    end else begin
      state_q <= state_d;
      if (out_wr) begin
        out_valid_q <= 1'b1;
        area_acc_q  <= last_q ? '0 : sum_new;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      esgn_q <= esgn;
      last_q <= in_data_i.last_triangle;
    end
    if (state_q == ST_SUM1) begin
      len_q <= {2'b00, sq[0]} + {2'b00, sq[1]};
    end
    if (out_wr) begin
      out_q.twice_area_sum <= sum_new;
      out_q.mesh_done      <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Lane completions must line up with the states that wait for them.
  a_cross_done_in_mul1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul1_done |-> state_q == ST_MUL1)
    else $error("cross product lanes finished outside their wait state");

  a_root_done_in_sqrt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == ST_SQRT)
    else $error("square root finished outside its wait state");

  a_clear_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_wr && last_q) |=> area_acc_q == '0)
    else $error("running sum not cleared after the last triangle");

  a_sum_no_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_wr && !last_q) |=> area_acc_q >= $past(area_acc_q))
    else $error("running sum wrapped instead of saturating");

  a_out_matches_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_wr && !last_q) |=> out_q.twice_area_sum == area_acc_q)
    else $error("result sum differs from the running sum");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for triangle_mesh_area_accumulator: directed and random
// triangle meshes, a predictor of the running twice-area sum and a field-by-field check.
// Depends on tma_pkg and the block's RTL only.
module testbench;

  localparam int unsigned CB           = tma_pkg::COORD_BITS;
  localparam int unsigned SUMB         = tma_pkg::SUM_BITS;
  localparam int unsigned TAIL_CYCLES  = 120;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 700;
  localparam int unsigned RANDOM_ITEMS = 1640;
  localparam logic [63:0] SUM_LIMIT    = 64'((65'd1 << SUMB) - 1);

  typedef struct {
    tma_pkg::tma_in_t tri_data;
    int unsigned      gap;
    bit               drain;
  } queued_tri_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_q = 1'b0;
  tma_pkg::tma_in_t  in_data_q = '0;
  logic              out_ready_q = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  tma_pkg::tma_out_t out_data_o;

  queued_tri_t       tri_pending[$];
  tma_pkg::tma_out_t sum_expect_q[$];

  logic [63:0] running_sum = '0;
  logic [63:0] peak_sum = '0;
  int unsigned n_sent = 0;
  int unsigned n_got = 0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned meshes_closed = 0;
  int unsigned flat_tris = 0;

  triangle_mesh_area_accumulator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_q),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_q),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [63:0] floor_root(logic [63:0] radicand);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= radicand) root = trial;
    end
    return root;
  endfunction

  // Advance the running sum by one triangle and return the result it must produce.
  function automatic tma_pkg::tma_out_t predict_area_sum(tma_pkg::tma_in_t t);
    longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
    logic [63:0] norm_sq, twice_area, acc;
    tma_pkg::tma_out_t res;
    e1x = longint'($signed(t.bx)) - longint'($signed(t.ax));
    e1y = longint'($signed(t.by_coord)) - longint'($signed(t.ay));
    e1z = longint'($signed(t.bz)) - longint'($signed(t.az));
    e2x = longint'($signed(t.cx_coord)) - longint'($signed(t.ax));
    e2y = longint'($signed(t.cy_coord)) - longint'($signed(t.ay));
    e2z = longint'($signed(t.cz_coord)) - longint'($signed(t.az));
    nx = e1y * e2z - e1z * e2y;
    ny = e1z * e2x - e1x * e2z;
    nz = e1x * e2y - e1y * e2x;
    norm_sq = 64'(nx * nx + ny * ny + nz * nz);
    twice_area = floor_root(norm_sq);
    if (twice_area == 0) flat_tris++;
    // Clamp at the top of the sum instead of wrapping.
    if (twice_area > SUM_LIMIT - running_sum) acc = SUM_LIMIT;
    else acc = running_sum + twice_area;
    if (acc > peak_sum) peak_sum = acc;
    res.twice_area_sum = acc[SUMB-1:0];
    res.mesh_done = t.last_triangle;
    if (t.last_triangle) begin
      running_sum = '0;
      meshes_closed++;
    end else begin
      running_sum = acc;
    end
    return res;
  endfunction

  function automatic tma_pkg::tma_in_t make_tri(int pax, int pay, int paz,
                                                int pbx, int pby, int pbz,
                                                int pcx, int pcy, int pcz, bit last);
    tma_pkg::tma_in_t t;
    t.ax = CB'(pax);
    t.ay = CB'(pay);
    t.az = CB'(paz);
    t.bx = CB'(pbx);
    t.by_coord = CB'(pby);
    t.bz = CB'(pbz);
    t.cx_coord = CB'(pcx);
    t.cy_coord = CB'(pcy);
    t.cz_coord = CB'(pcz);
    t.last_triangle = last;
    return t;
  endfunction

  function automatic int rand_signed(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Draw one triangle of a random shape: wide, tiny, extreme corners, collinear or pinched.
  function automatic tma_pkg::tma_in_t random_tri(bit last, bit corners_only);
    int kind, pax, pay, paz, dx, dy, dz, m, n;
    tma_pkg::tma_in_t t;
    kind = corners_only ? 10 : int'($urandom_range(0, 9));
    t = tma_pkg::tma_in_t'({$urandom, $urandom, $urandom, $urandom});
    if (kind >= 5 && kind <= 7) begin
      pax = rand_signed(-2000, 1999);
      pay = rand_signed(-2000, 1999);
      paz = rand_signed(-2000, 1999);
      t = make_tri(pax, pay, paz,
                   pax + rand_signed(-40, 40), pay + rand_signed(-40, 40),
                   paz + rand_signed(-40, 40),
                   pax + rand_signed(-40, 40), pay + rand_signed(-40, 40),
                   paz + rand_signed(-40, 40), last);
    end else if (kind == 8) begin
      pax = rand_signed(-1000, 1000);
      pay = rand_signed(-1000, 1000);
      paz = rand_signed(-1000, 1000);
      dx = rand_signed(-15, 15);
      dy = rand_signed(-15, 15);
      dz = rand_signed(-15, 15);
      m = rand_signed(-40, 40);
      n = rand_signed(-40, 40);
      t = make_tri(pax, pay, paz, pax + m * dx, pay + m * dy, paz + m * dz,
                   pax + n * dx, pay + n * dy, paz + n * dz, last);
    end else if (kind == 9) begin
      // Two vertices coincide.
      if ($urandom_range(0, 1)) begin
        t.bx = t.ax;
        t.by_coord = t.ay;
        t.bz = t.az;
      end else begin
        t.cx_coord = t.bx;
        t.cy_coord = t.by_coord;
        t.cz_coord = t.bz;
      end
    end else if (kind == 10) begin
      t = make_tri($urandom_range(0, 1) ? -2048 : 2047, $urandom_range(0, 1) ? -2048 : 2047,
                   $urandom_range(0, 1) ? -2048 : 2047, $urandom_range(0, 1) ? -2048 : 2047,
                   $urandom_range(0, 1) ? -2048 : 2047, $urandom_range(0, 1) ? -2048 : 2047,
                   $urandom_range(0, 1) ? -2048 : 2047, $urandom_range(0, 1) ? -2048 : 2047,
                   $urandom_range(0, 1) ? -2048 : 2047, last);
    end
    t.last_triangle = last;
    return t;
  endfunction

  task automatic push_tri(tma_pkg::tma_in_t t, bit calm, bit drain);
    queued_tri_t q;
    q.tri_data = t;
    q.gap = calm ? 0 : $urandom_range(0, 12);
    q.drain = drain;
    tri_pending.push_back(q);
  endtask

  // Sender: present queued triangles, idle between them, predict each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin : drive_triangles
    bit taken;
    int unsigned sent_now;
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_data_q <= '0;
    end else begin
      taken = in_valid_q && in_ready_o;
      if (taken) begin
        sum_expect_q.push_back(predict_area_sum(in_data_q));
        tx_wait = (tri_pending.size() > 0) ? tri_pending[0].gap : 0;
      end
      sent_now = n_sent + int'(taken);
      n_sent <= sent_now;
      if (in_valid_q && !taken) begin
        // hold the offered transaction
      end else if (tri_pending.size() == 0) begin
        in_valid_q <= 1'b0;
      end else if (tx_wait > 0) begin
        tx_wait--;
        in_valid_q <= 1'b0;
      end else if (tri_pending[0].drain && n_got != sent_now) begin
        in_valid_q <= 1'b0;
      end else begin
        in_valid_q <= 1'b1;
        in_data_q <= tri_pending[0].tri_data;
        tri_pending.pop_front();
      end
    end
  end

  // Receiver: check each result against the oldest prediction, then stall at random.
  always @(posedge clk_i or negedge rst_ni) begin : check_sums
    tma_pkg::tma_out_t want;
    if (!rst_ni) begin
      out_ready_q <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_q) begin
        if (sum_expect_q.size() == 0) begin
          $error("unexpected result: twice_area_sum %0d mesh_done %0b",
                 out_data_o.twice_area_sum, out_data_o.mesh_done);
          mismatches++;
        end else begin
          want = sum_expect_q.pop_front();
          if (out_data_o.twice_area_sum !== want.twice_area_sum) begin
            $error("twice_area_sum: expected %0d, got %0d",
                   want.twice_area_sum, out_data_o.twice_area_sum);
            mismatches++;
          end
          if (out_data_o.mesh_done !== want.mesh_done) begin
            $error("mesh_done: expected %0b, got %0b", want.mesh_done, out_data_o.mesh_done);
            mismatches++;
          end
        end
        n_got <= n_got + 1;
        // Hold off once for a long stretch so the block backs up into its input.
        if (n_got + 1 == HOLD_AT) rx_wait = HOLD_CYCLES;
        else if ((n_got / 128) % 4 == 2) rx_wait = 0;
        else rx_wait = $urandom_range(0, 12);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ready_q <= (rx_wait == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_q && in_ready_o) || (out_valid_o && out_ready_q)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : run_meshes
    int unsigned queued, mesh_len, mesh_no;
    bit calm, ragged;
    // Directed: extremes, orientation, degenerate shapes, sqrt flooring, back-to-back ends.
    push_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0, 1'b0);
    push_tri(make_tri(-2048, -2048, -2048, 2047, -2048, -2048, -2048, 2047, -2048, 1'b0),
             1'b0, 1'b0);
    push_tri(make_tri(2047, -2048, -2048, -2048, 2047, -2048, -2048, -2048, 2047, 1'b0),
             1'b0, 1'b0);
    push_tri(make_tri(2047, -2048, -2048, -2048, -2048, 2047, -2048, 2047, -2048, 1'b1),
             1'b0, 1'b0);
    push_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b1), 1'b0, 1'b0);
    push_tri(make_tri(0, 0, 0, 1, 1, 1, 2047, 2047, 2047, 1'b0), 1'b0, 1'b0);
    push_tri(make_tri(-2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048, 1'b0),
             1'b0, 1'b0);
    push_tri(make_tri(2047, 2047, 2047, -2048, -2048, -2048, 2047, -2048, 2047, 1'b1),
             1'b0, 1'b0);
    push_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 1, 1'b0), 1'b1, 1'b0);
    push_tri(make_tri(0, 0, 0, 2, 1, 0, 0, 3, 1, 1'b0), 1'b1, 1'b0);
    push_tri(make_tri(-1, -1, -1, 2047, 0, -2048, -2048, 2047, 0, 1'b1), 1'b1, 1'b0);
    push_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1, 1'b0);
    push_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b1), 1'b1, 1'b0);
    push_tri(make_tri(-1, -1, -1, -1, -1, -1, 5, 5, 5, 1'b1), 1'b0, 1'b0);
    push_tri(make_tri(-2048, 2047, -2048, 2047, -2048, 2047, 0, 0, 0, 1'b0), 1'b0, 1'b0);
    push_tri(make_tri(1, -2048, 2047, 1, -2048, 2047, 1, -2048, 2047, 1'b1), 1'b0, 1'b0);

    // One long mesh of near-maximal triangles to drive the sum up.
    for (int i = 0; i < 150; i++) push_tri(random_tri(i == 149, 1'b1), 1'b0, i == 0);

    queued = 0;
    mesh_no = 0;
    while (queued < RANDOM_ITEMS) begin
      mesh_len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 24);
      calm = (mesh_no % 6 == 3);
      ragged = ($urandom_range(0, 6) == 0);
      for (int i = 0; i < int'(mesh_len); i++) begin
        push_tri(random_tri(ragged ? ($urandom_range(0, 3) == 0) : (i == mesh_len - 1), 1'b0),
                 calm, queued == 1200);
        queued++;
      end
      mesh_no++;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (!(tri_pending.size() == 0 && !in_valid_q && n_got == n_sent)
           && idle_cycles < IDLE_LIMIT)
      @(negedge clk_i);

    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: FAIL");
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk_i);
      if (sum_expect_q.size() != 0) begin
        $error("%0d results never arrived", sum_expect_q.size());
        mismatches++;
      end
      $display("covered %0d triangles in %0d closed meshes, %0d of them degenerate",
               n_sent, meshes_closed, flat_tris);
      $display("largest running sum %0d, %0d mismatches", peak_sum, mismatches);
      if (mismatches == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tma_pkg.sv
sv/tma_mul.sv
sv/tma_sqrt.sv
sv/triangle_mesh_area_accumulator.sv
sim/testbench.sv
